FILE: rtl/core/pkb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkb_pkg: shared types and constants for the peak bin accumulator
// Transaction payload structs, sequencer states, action and register codes.
// ----------------------------------------------------------------------------
package pkb_pkg;

  localparam int POS_W  = 32;   // position / quotient width
  localparam int SPB_W  = 17;   // samples_per_bin width
  localparam int SMP_W  = 24;   // Q1.23 sample width
  localparam int IDX_W  = 12;   // bin index field width
  localparam int CNT_W  = 33;   // bin counter width

  localparam logic [SPB_W-1:0] SPB_RESET = 17'd256;

  // config register index (paddr[2])
  localparam logic CFG_IDX_SPB = 1'b0;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_START  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } pkb_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_MRG,
    ST_DONE
  } pkb_state_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [POS_W-1:0]        position;
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
    logic                    is_stereo;
    logic [IDX_W-1:0]        read_index;
  } pkb_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] bin_index;
    logic [SMP_W-1:0] peak_left;
    logic [SMP_W-1:0] peak_right;
    logic             bin_valid;
    logic [CNT_W-1:0] bins_reached;
    logic [CNT_W-1:0] bins_lost;
  } pkb_out_t;

endpackage
`default_nettype wire

FILE: rtl/core/peak_bin_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// peak_bin_accumulator: per-bin peak magnitude envelope
// Folds audio samples into peak bins, one result transaction per input item.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_stall / in_item carry one action per transaction: a sample
//   (bin = position / samples_per_bin), a start-pass, or a read of one bin.
//   out_valid / out_stall / out_item return exactly one result per item,
//   with the current bins-reached and bins-lost counts. The user writes
//   samples_per_bin (APB address 0) only while idle, unchecked by the block.
// Sequencing:
//   A sample runs the 32-step serial divider, then lookup, merge and output
//   load; a read runs lookup, merge (RAM registered read) and output load;
//   a start-pass, an ignored item or a sample with samples_per_bin zero goes
//   straight to output load. One item is worked at a time; in_stall is high
//   while an item is in flight and during reset.
// Output:
//   Results sit in an output register. While out_stall holds it full, the
//   sequencer waits in its final state with the next result; the next input
//   may be accepted as soon as the previous result has been registered.
// Reset:
//   rst clears the counters, the sequencer and the output valid, and reloads
//   samples_per_bin to 256. Bin storage is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module peak_bin_accumulator
  import pkb_pkg::*;
#(
  parameter int BIN_CAPACITY = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire pkb_in_t     in_item,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output pkb_out_t         out_item,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = (BIN_CAPACITY > 1) ? $clog2(BIN_CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP33 = CNT_W'(BIN_CAPACITY);
  localparam int ENT_W = 2 * SMP_W;

  // Q1.23 magnitude; the most negative code maps to 0x800000 exactly
  function automatic logic [SMP_W-1:0] mag(input logic [SMP_W-1:0] v);
    mag = v[SMP_W-1] ? (~v + 1'b1) : v;
  endfunction

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [SPB_W-1:0] spb;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_SPB);
  assign prdata = (paddr[2] == CFG_IDX_SPB) ? {{(32-SPB_W){1'b0}}, spb} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      spb <= SPB_RESET;
    end else if (cfg_wr) begin
      spb <= pwdata[SPB_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  pkb_state_t state, state_next;

  logic accept;
  logic div_start;
  logic div_done;
  logic load_out;
  logic ram_we;

  logic [1:0]       op;         // action of the item in flight
  logic [POS_W-1:0] bin;        // quotient, or read index for a read
  logic [SMP_W-1:0] mag_l;
  logic [SMP_W-1:0] mag_r;
  logic             first;      // bin at or beyond the reached count
  logic             hit;        // stored bin (sample in capacity / read ok)

  logic [CNT_W-1:0] reached;
  logic [CNT_W-1:0] reached_next;

  logic [IDX_W-1:0] res_bin;
  logic [SMP_W-1:0] res_l;
  logic [SMP_W-1:0] res_r;
  logic             res_valid;

  logic [POS_W-1:0] quotient;
  logic [ENT_W-1:0] rdata;
  logic [ENT_W-1:0] wdata;
  logic [SMP_W-1:0] new_l;
  logic [SMP_W-1:0] new_r;
  logic [SMP_W-1:0] old_l;
  logic [SMP_W-1:0] old_r;

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.action)
            ACT_SAMPLE: begin
              if (spb != '0) begin
                div_start  = 1'b1;
                state_next = ST_DIV;
              end else begin
                state_next = ST_DONE;
              end
            end
            ACT_READ: state_next = ST_LOOK;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: state_next = ST_MRG;
      ST_MRG: begin
        ram_we     = (op == ACT_SAMPLE) && hit;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // serial divider and shared bin store
  // --------------------------------------------------------------------------
  pkb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_item.position),
    .divisor  (spb),
    .done     (div_done),
    .quotient (quotient)
  );

  pkb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (BIN_CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bin[AW-1:0]),
    .wdata (wdata),
    .raddr (bin[AW-1:0]),
    .rdata (rdata)
  );

  // merge: a later sample in a bin takes the max with the stored peaks
  assign old_l = rdata[ENT_W-1:SMP_W];
  assign old_r = rdata[SMP_W-1:0];
  assign new_l = (!first && (old_l > mag_l)) ? old_l : mag_l;
  assign new_r = (!first && (old_r > mag_r)) ? old_r : mag_r;
  assign wdata = {new_l, new_r};

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= in_item.action;
      bin   <= {{(POS_W-IDX_W){1'b0}}, in_item.read_index};
      mag_l <= mag(in_item.left_sample);
      mag_r <= in_item.is_stereo ? mag(in_item.right_sample) : mag(in_item.left_sample);
      res_bin   <= '0;
      res_l     <= '0;
      res_r     <= '0;
      res_valid <= 1'b0;
    end
    if (state == ST_DIV && div_done) begin
      bin <= quotient;
    end
    if (state == ST_LOOK) begin
      first <= ({1'b0, bin} >= reached);
      // sample: bin inside capacity; read: index inside capacity and reached
      hit   <= ({1'b0, bin} < CAP33) && ((op == ACT_SAMPLE) || ({1'b0, bin} < reached));
    end
    if (state == ST_MRG && hit) begin
      res_bin   <= bin[IDX_W-1:0];
      res_valid <= 1'b1;
      if (op == ACT_SAMPLE) begin
        res_l <= new_l;
        res_r <= new_r;
      end else begin
        res_l <= old_l;
        res_r <= old_r;
      end
    end
  end

  // bins-reached count
  always_comb begin
    reached_next = reached;
    if (accept && in_item.action == ACT_START) begin
      reached_next = '0;
    end else if (state == ST_MRG && op == ACT_SAMPLE && first) begin
      reached_next = CNT_W'(bin) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= '0;
    end else begin
      reached <= reached_next;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.bin_index    <= res_bin;
      out_item.peak_left    <= res_l;
      out_item.peak_right   <= res_r;
      out_item.bin_valid    <= res_valid;
      out_item.bins_reached <= reached;
      out_item.bins_lost    <= (reached > CAP33) ? (reached - CAP33) : '0;
    end
  end

`ifndef SYNTHESIS
  // a valid bin always lies below a nonzero reached count
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bin_valid |-> out_item.bins_reached != '0)
    else $error("valid bin reported with zero bins reached");

  // lost count is the excess of reached over capacity
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.bins_lost == '0) ||
                  (out_item.bins_reached == out_item.bins_lost + CAP33))
    else $error("bins_lost inconsistent with bins_reached");

  // the divider finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside divide phase");

  // a store write always follows the lookup read of the same bin
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(state) == ST_LOOK)
    else $error("bin store written without prior lookup");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/pkb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkb_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pkb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/pkb_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkb_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, position by samples_per_bin.
// ----------------------------------------------------------------------------
module pkb_div
  import pkb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [POS_W-1:0] dividend,
  input  wire logic [SPB_W-1:0] divisor,
  output logic                  done,
  output logic      [POS_W-1:0] quotient
);

  localparam int CW = $clog2(POS_W);
  localparam logic [CW-1:0] LAST = CW'(POS_W - 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [POS_W-1:0] dq;
  logic [SPB_W-1:0] rem;
  logic [SPB_W-1:0] dvs;

  logic [SPB_W+1:0] diff;
  logic             ge;

  // trial subtract of the shifted partial remainder
  assign diff = {1'b0, rem, dq[POS_W-1]} - {2'b00, dvs};
  assign ge   = !diff[SPB_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[SPB_W-1:0] : {rem[SPB_W-2:0], dq[POS_W-1]};
      dq  <= {dq[POS_W-2:0], ge};
    end
  end

  assign quotient = dq;

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for peak_bin_accumulator
// Runs a directed table and then random phases of action transactions, each
// phase under its own samples_per_bin setting, with bursty input idling and
// output stall but in the last. Each result is checked field by field against
// a typed row or a behavioral copy of the bin store and bins-reached counter.
// ----------------------------------------------------------------------------
module tb;
  import pkb_pkg::*;

  localparam int BIN_CAP = 4096;
  // The limit lies well above the time that a sample holds the block, a config
  // write plus drain pause takes, or the output stall bursts add per result;
  // a quiet stretch that long only happens when the block hangs.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 60;
  localparam int PHASE_ITEMS    = 150;
  localparam int NUM_PHASES     = 10;
  localparam logic [2:0] SPB_ADDR = {CFG_IDX_SPB, 2'b00};

  typedef struct {
    bit          is_cfg;
    logic [31:0] cfg_value;
    pkb_in_t     item;
    bit          has_want;
    pkb_out_t    want;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pkb_in_t     in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pkb_out_t    out_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // --------------------------------------------------------------------------
  // Predictor state: bin peaks, which bins hold defined data, the counter
  // and the register copy
  // --------------------------------------------------------------------------
  logic [SMP_W-1:0] peak_l_mem [0:BIN_CAP-1];
  logic [SMP_W-1:0] peak_r_mem [0:BIN_CAP-1];
  bit               bin_written [0:BIN_CAP-1];
  logic [CNT_W-1:0] reached_cnt;
  logic [SPB_W-1:0] spb_cfg;
  logic [31:0]      walk_pos;       // position of the in-order pass walker

  pkb_out_t expected_results[$];
  dir_row_t dir_rows[$];

  int err_count       = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int cfg_writes      = 0;
  int stall_left      = 0;
  bit idle_en         = 1'b1;
  bit stall_en        = 1'b1;

  peak_bin_accumulator #(
    .BIN_CAPACITY(BIN_CAP)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Q1.23 magnitude; the most negative code maps to 0x800000 exactly
  function automatic logic [SMP_W-1:0] magnitude(logic [SMP_W-1:0] s);
    return s[SMP_W-1] ? (~s + 1'b1) : s;
  endfunction

  // Applies one input transaction to the predictor state and returns the
  // result the block must produce for it.
  function automatic pkb_out_t fold_item(pkb_in_t it);
    pkb_out_t         res;
    logic [POS_W-1:0] q;
    logic [SMP_W-1:0] l;
    logic [SMP_W-1:0] r;
    bit               first;
    res = '0;
    case (it.action)
      ACT_START: reached_cnt = '0;
      ACT_READ: begin
        if (CNT_W'(it.read_index) < reached_cnt) begin
          res.bin_index  = it.read_index;
          res.peak_left  = peak_l_mem[it.read_index];
          res.peak_right = peak_r_mem[it.read_index];
          res.bin_valid  = 1'b1;
        end
      end
      ACT_SAMPLE: begin
        // zero samples per bin: sample is dropped, counts still reported
        if (spb_cfg != '0) begin
          q     = it.position / POS_W'(spb_cfg);
          first = CNT_W'(q) >= reached_cnt;
          l     = magnitude(it.left_sample);
          r     = it.is_stereo ? magnitude(it.right_sample) : l;
          // bins past capacity only move the counter
          if (q < BIN_CAP) begin
            if (!first) begin
              if (peak_l_mem[q] > l) l = peak_l_mem[q];
              if (peak_r_mem[q] > r) r = peak_r_mem[q];
            end
            peak_l_mem[q]  = l;
            peak_r_mem[q]  = r;
            bin_written[q] = 1'b1;
            res.bin_index  = q[IDX_W-1:0];
            res.peak_left  = l;
            res.peak_right = r;
            res.bin_valid  = 1'b1;
          end
          if (first) reached_cnt = CNT_W'(q) + 1'b1;
        end
      end
      default: ;
    endcase
    res.bins_reached = reached_cnt;
    res.bins_lost    = (reached_cnt > CNT_W'(BIN_CAP)) ? reached_cnt - CNT_W'(BIN_CAP) : '0;
    return res;
  endfunction

  // False when the transaction would touch a bin that was never written:
  // a read below the counter, or a merge into a skipped bin.
  function automatic bit safe_item(pkb_in_t it);
    logic [POS_W-1:0] q;
    if (it.action == ACT_READ)
      return !(CNT_W'(it.read_index) < reached_cnt) || bin_written[it.read_index];
    if (it.action == ACT_SAMPLE && spb_cfg != '0) begin
      q = it.position / POS_W'(spb_cfg);
      if (CNT_W'(q) < reached_cnt && q < BIN_CAP) return bin_written[q];
    end
    return 1'b1;
  endfunction

  function automatic pkb_in_t mk_in(pkb_action_t a, logic [31:0] pos, logic [23:0] l,
                                    logic [23:0] r, bit st, logic [11:0] idx);
    pkb_in_t it;
    it.action       = a;
    it.position     = pos;
    it.left_sample  = l;
    it.right_sample = r;
    it.is_stereo    = st;
    it.read_index   = idx;
    return it;
  endfunction

  function automatic pkb_out_t mk_out(logic [11:0] bin, logic [23:0] l, logic [23:0] r,
                                      bit v, logic [32:0] reached, logic [32:0] lost);
    pkb_out_t o;
    o.bin_index    = bin;
    o.peak_left    = l;
    o.peak_right   = r;
    o.bin_valid    = v;
    o.bins_reached = reached;
    o.bins_lost    = lost;
    return o;
  endfunction

  function automatic void add_row(pkb_in_t it);
    dir_row_t row;
    row = '{1'b0, 32'd0, it, 1'b0, pkb_out_t'('0)};
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_typed(pkb_in_t it, pkb_out_t want);
    dir_row_t row;
    row = '{1'b0, 32'd0, it, 1'b1, want};
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_cfg(logic [31:0] v);
    dir_row_t row;
    row = '{1'b1, v, pkb_in_t'('0), 1'b0, pkb_out_t'('0)};
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Random transaction: mostly an in-order pass walk with random content,
  // then reads, pass starts, unused actions and samples at random positions.
  task automatic make_random_item(output pkb_in_t it);
    int unsigned      pick;
    logic [63:0]      step;
    logic [63:0]      nxt;
    logic [63:0]      bound;
    logic [CNT_W-1:0] lim;
    it.action       = ACT_SAMPLE;
    it.position     = $urandom;
    it.left_sample  = SMP_W'($urandom);
    it.right_sample = SMP_W'($urandom);
    it.is_stereo    = 1'($urandom_range(0, 1));
    it.read_index   = IDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: step = 64'($urandom_range(0, 3));
        6, 7, 8:          step = 64'($urandom_range(0, 2 * spb_cfg));
        default:          step = 64'($urandom_range(0, 63)) * spb_cfg;  // skip bins
      endcase
      nxt = 64'(walk_pos) + step;
      if (nxt > 64'hFFFF_FFFF) begin
        it.action = ACT_START;
      end else begin
        it.position = nxt[31:0];
        walk_pos    = nxt[31:0];
      end
    end else if (pick < 75) begin
      it.action = ACT_READ;
      lim = (reached_cnt < CNT_W'(BIN_CAP)) ? reached_cnt : CNT_W'(BIN_CAP);
      if (lim != '0 && $urandom_range(0, 3) != 0)
        it.read_index = IDX_W'($urandom_range(0, 32'(lim) - 1));
    end else if (pick < 80) begin
      it.action = ACT_START;
    end else if (pick < 85) begin
      it.action = ACT_NONE;
    end else if (pick < 92) begin
      // land around the capacity edge
      bound = 64'(spb_cfg) * (BIN_CAP + 100);
      if (bound > 64'hFFFF_FFFF) bound = 64'hFFFF_FFFF;
      it.position = $urandom_range(0, bound[31:0]);
    end
    // otherwise: a sample anywhere in the 32-bit position space

    if (!safe_item(it)) begin
      // redirect to the first bin not yet reached, which always overwrites
      nxt = 64'(reached_cnt) * spb_cfg;
      if (spb_cfg != '0 && nxt <= 64'hFFFF_FFFF) begin
        it.action   = ACT_SAMPLE;
        it.position = nxt[31:0];
        walk_pos    = nxt[31:0];
      end else begin
        it.action = ACT_START;
      end
    end
    if (it.action == ACT_START) walk_pos = '0;
  endtask

  // One input transaction; the expectation is queued at the accepting edge.
  task automatic send_item(pkb_in_t it, bit has_want, pkb_out_t want);
    pkb_out_t pred;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pred = fold_item(it);
    expected_results.insert(expected_results.size(), has_want ? want : pred);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // let the sequencer fall back to idle after its last output load
    repeat (4) @(posedge clk);
  endtask

  // APB write of samples_per_bin followed by a readback, only while idle
  task automatic set_spb(logic [31:0] val);
    logic [31:0] rd;
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SPB_ADDR;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    spb_cfg = val[SPB_W-1:0];
    cfg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(val[SPB_W-1:0])) report_mismatch("samples_per_bin readback", rd,
                                                    32'(val[SPB_W-1:0]));
  endtask

  // --------------------------------------------------------------------------
  // Output side: bursty out_stall, high through each random burst
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    pkb_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no pending transaction", out_item.bins_reached, 0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_item.bin_index !== want.bin_index)
          report_mismatch("bin_index", out_item.bin_index, want.bin_index);
        if (out_item.peak_left !== want.peak_left)
          report_mismatch("peak_left", out_item.peak_left, want.peak_left);
        if (out_item.peak_right !== want.peak_right)
          report_mismatch("peak_right", out_item.peak_right, want.peak_right);
        if (out_item.bin_valid !== want.bin_valid)
          report_mismatch("bin_valid", out_item.bin_valid, want.bin_valid);
        if (out_item.bins_reached !== want.bins_reached)
          report_mismatch("bins_reached", out_item.bins_reached, want.bins_reached);
        if (out_item.bins_lost !== want.bins_lost)
          report_mismatch("bins_lost", out_item.bins_lost, want.bins_lost);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transaction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    pkb_in_t     it;
    int          counted;
    logic [31:0] spb_next;
    spb_cfg     = SPB_RESET;
    reached_cnt = '0;
    walk_pos    = '0;

    // Directed table, samples_per_bin at its reset value of 256 first.
    // Read right after reset: nothing reached yet.
    add_typed(mk_in(ACT_READ, 32'd0, 24'd0, 24'd0, 1'b0, 12'd0),
              mk_out(12'd0, 24'd0, 24'd0, 1'b0, 33'd0, 33'd0));
    // unused action code
    add_typed(mk_in(ACT_NONE, 32'hFFFF_FFFF, 24'h7FFFFF, 24'h800000, 1'b1, 12'hFFF),
              mk_out(12'd0, 24'd0, 24'd0, 1'b0, 33'd0, 33'd0));
    // most negative mono sample opens bin 0
    add_typed(mk_in(ACT_SAMPLE, 32'd0, 24'h800000, 24'h000000, 1'b0, 12'd0),
              mk_out(12'd0, 24'h800000, 24'h800000, 1'b1, 33'd1, 33'd0));
    add_row(mk_in(ACT_SAMPLE, 32'd255, 24'h7FFFFF, 24'hFFFFFF, 1'b1, 12'd0));
    add_row(mk_in(ACT_SAMPLE, 32'd256, 24'h000000, 24'h7FFFFF, 1'b1, 12'd0));
    add_row(mk_in(ACT_READ, 32'd0, 24'd0, 24'd0, 1'b0, 12'd1));
    // read at the counter: not reached
    add_typed(mk_in(ACT_READ, 32'd0, 24'd0, 24'd0, 1'b0, 12'd2),
              mk_out(12'd0, 24'd0, 24'd0, 1'b0, 33'd2, 33'd0));
    // far past capacity
    add_row(mk_in(ACT_SAMPLE, 32'hFFFF_FFFF, 24'h000001, 24'h000000, 1'b0, 12'd0));
    add_row(mk_in(ACT_READ, 32'd0, 24'd0, 24'd0, 1'b0, 12'd0));
    add_typed(mk_in(ACT_START, 32'd0, 24'd0, 24'd0, 1'b0, 12'd0),
              mk_out(12'd0, 24'd0, 24'd0, 1'b0, 33'd0, 33'd0));
    // new pass overwrites old bin 0 contents
    add_row(mk_in(ACT_SAMPLE, 32'd1, 24'hFFFFFB, 24'h000007, 1'b1, 12'd0));
    add_row(mk_in(ACT_READ, 32'd0, 24'd0, 24'd0, 1'b0, 12'd0));
    // one sample per bin: top position gives the largest counts
    add_cfg(32'd1);
    add_typed(mk_in(ACT_SAMPLE, 32'hFFFF_FFFF, 24'h7FFFFF, 24'd0, 1'b0, 12'd0),
              mk_out(12'd0, 24'd0, 24'd0, 1'b0, 33'h1_0000_0000, 33'h0_FFFF_F000));
    add_typed(mk_in(ACT_START, 32'd0, 24'd0, 24'd0, 1'b0, 12'd0),
              mk_out(12'd0, 24'd0, 24'd0, 1'b0, 33'd0, 33'd0));
    // last stored bin, then the first lost one
    add_row(mk_in(ACT_SAMPLE, 32'd4095, 24'h800000, 24'h800000, 1'b1, 12'd0));
    add_row(mk_in(ACT_SAMPLE, 32'd4096, 24'h123456, 24'd0, 1'b0, 12'd0));
    add_row(mk_in(ACT_READ, 32'd0, 24'd0, 24'd0, 1'b0, 12'd4095));
    // zero samples per bin: sample dropped
    add_cfg(32'd0);
    add_row(mk_in(ACT_SAMPLE, 32'd10, 24'h400000, 24'd0, 1'b0, 12'd0));
    // all ones on the bus: largest 17-bit setting
    add_cfg(32'hFFFF_FFFF);
    add_row(mk_in(ACT_SAMPLE, 32'hFFFF_FFFF, 24'h000100, 24'hFFFF00, 1'b1, 12'd0));
    add_cfg(32'd65536);
    add_typed(mk_in(ACT_START, 32'd0, 24'd0, 24'd0, 1'b0, 12'd0),
              mk_out(12'd0, 24'd0, 24'd0, 1'b0, 33'd0, 33'd0));
    add_row(mk_in(ACT_SAMPLE, 32'd65535, 24'h123456, 24'hABCDEF, 1'b1, 12'd0));
    add_row(mk_in(ACT_SAMPLE, 32'd65536, 24'hFEDCBA, 24'h654321, 1'b1, 12'd0));
    add_row(mk_in(ACT_READ, 32'd0, 24'd0, 24'd0, 1'b0, 12'd0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) set_spb(dir_rows[k].cfg_value);
      else send_item(dir_rows[k].item, dir_rows[k].has_want, dir_rows[k].want);
    end

    // Random phases, each with its own bin size. The last one runs with
    // no idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       spb_next = 32'd1;
        1:       spb_next = 32'hFFFF_FFFF;
        2:       spb_next = 32'd2;
        3:       spb_next = $urandom_range(1, 16);
        4:       spb_next = 32'd0;
        5:       spb_next = 32'd65536;
        6:       spb_next = $urandom_range(1, 131071);
        7:       spb_next = 32'd256;
        8:       spb_next = $urandom_range(3, 600);
        default: spb_next = $urandom_range(1, 8);
      endcase
      set_spb(spb_next);
      if (p == NUM_PHASES - 1) begin
        idle_en  = 1'b0;
        stall_en = 1'b0;
      end
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        make_random_item(it);
        if (it.action != ACT_NONE) counted++;
        send_item(it, 1'b0, pkb_out_t'('0));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch("results never returned", expected_results.size(), 0);
    $display("Run: %0d transactions in, %0d results checked, %0d register writes",
             items_sent, results_checked, cfg_writes);
    $display("Covered: samples, pass starts, reads, unused action, lost bins, bin sizes 0..131071");
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
